FILE: design/tmps_pkg.sv
package tmps_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SUM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_SUM      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_PA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATMOS_PA      = 3'd4;

  // Register values after reset
  localparam logic [DATA_W-1:0] ZERO_SUM_RST      = 16'd11469;
  localparam logic [DATA_W-1:0] SPAN_SUM_RST      = 16'd45875;
  localparam logic [DATA_W-1:0] FULL_SCALE_PA_RST = 16'd10000;
  localparam logic [DATA_W-1:0] OFFSET_PA_RST     = 16'd2000;
  localparam logic [DATA_W-1:0] ATMOS_PA_RST      = 16'd1000;

  // Burst status from the accumulator
  typedef struct packed {
    logic              full;
    logic [DATA_W-1:0] tsum;
  } acc_status_t;

  // Request to the serial multiply-divide unit: a * b / d
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] d;
  } md_req_t;

endpackage

FILE: design/tmps_accum.sv
module tmps_accum
  import tmps_pkg::*;
#(
  parameter int SAMPLES  = 16,
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                clear,
  input  logic [SAMPLE_W-1:0] sample,
  output acc_status_t         status
);

  localparam int SW    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W = SW + $clog2(SAMPLES) + 1;
  localparam int TW    = (SUM_W > DATA_W) ? SUM_W : DATA_W;

  logic [SW-1:0]    s;
  logic [SUM_W-1:0] sum;
  logic [SW-1:0]    largest;
  logic [SW-1:0]    smallest;
  logic [CNT_W-1:0] count;
  logic             full;
  logic [TW-1:0]    diff;

  assign s = sample[SW-1:0];

  // Fold each sample into the burst, restart the burst on clear
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum      <= '0;
      largest  <= '0;
      smallest <= '1;
      count    <= '0;
      full     <= 1'b0;
    end else if (take) begin
      sum <= sum + SUM_W'(s);
      if (s > largest) begin
        largest <= s;
      end
      if (s < smallest) begin
        smallest <= s;
      end
      if (count == CNT_W'(SAMPLES - 1)) begin
        count <= '0;
        full  <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // Drop one maximum and one minimum, saturate to the output width
  assign diff = TW'(sum) - TW'(largest) - TW'(smallest);

  assign status.full = full;
  assign status.tsum = (diff > TW'({DATA_W{1'b1}})) ? {DATA_W{1'b1}} : diff[DATA_W-1:0];

endmodule

FILE: design/tmps_muldiv.sv
module tmps_muldiv
  import tmps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  md_req_t           req,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  localparam int CNT_W = $clog2(PROD_W);

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] work;
  logic [DATA_W-1:0] mplier;
  logic [DATA_W-1:0] mcand;
  logic [DATA_W-1:0] divisor;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_sub;
  logic              ge;

  // One quotient bit per cycle: shift in the next dividend bit, try the divisor
  assign trial     = {rem, work[PROD_W-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  // Control: sixteen multiply steps, then thirty-two divide steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            state <= M_MUL;
            cnt   <= '0;
          end
        end
        M_MUL: begin
          if (cnt == CNT_W'(DATA_W - 1)) begin
            state <= M_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_DIV: begin
          if (cnt == CNT_W'(PROD_W - 1)) begin
            state <= M_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  // Datapath: MSB-first shift-add multiply, then restoring divide in place
  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) begin
          work    <= '0;
          mplier  <= req.a;
          mcand   <= req.b;
          divisor <= req.d;
        end
      end
      M_MUL: begin
        work   <= {work[PROD_W-2:0], 1'b0} +
                  (mplier[DATA_W-1] ? PROD_W'(mcand) : '0);
        mplier <= {mplier[DATA_W-2:0], 1'b0};
        rem    <= '0;
      end
      M_DIV: begin
        rem  <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
        work <= {work[PROD_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  assign quotient = work;

endmodule

FILE: design/trimmed_mean_pressure_scaler_unit.sv
// Trimmed-mean pressure scaler.
// Sample channel: sample_valid / sample_stall carry one ADC sample per
// transaction. The block sums SAMPLES samples into a burst, then drops one
// maximum and one minimum and scales the trimmed sum as a 4-20 mA reading.
// Result channel: result_valid / result_stall carry pressure_pa and
// trimmed_sum, one transaction per burst.
// Config channel: cfg_valid / cfg_ready write cfg_data to the register at
// cfg_index (zero_sum, span_sum, full_scale_pa, offset_pa, atmos_pa);
// unknown indexes are ignored. Write only while the block is idle.
// Throughput: one sample per cycle inside a burst. After the last sample of
// a burst the sample channel stalls through the trim, the serial unit's
// 16 shift-add multiply steps and 32 restoring divide steps, clamp and load.
// A result sits in an output register; while the receiver stalls, the next
// burst is still collected and scaled and waits in S_LOAD for a free slot.
// Reset (rst, synchronous) clears the burst, the result register and loads
// the default calibration values.
module trimmed_mean_pressure_scaler_unit
  import tmps_pkg::*;
#(
  parameter int SAMPLES  = 16,
  parameter int ADC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [DATA_W-1:0]    pressure_pa,
  output logic [DATA_W-1:0]    trimmed_sum,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_CLAMP = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [DATA_W-1:0] zero_sum;
  logic [DATA_W-1:0] span_sum;
  logic [DATA_W-1:0] full_scale_pa;
  logic [DATA_W-1:0] offset_pa;
  logic [DATA_W-1:0] atmos_pa;

  logic [1:0]        state;
  logic              take;
  logic              clear;
  acc_status_t       acc;
  md_req_t           md_req;
  logic              md_done;
  logic [PROD_W-1:0] md_quot;
  logic [DATA_W-1:0] tsum;
  logic              below_zero;
  logic [DATA_W-1:0] wind;
  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] over;
  logic [DATA_W-1:0] wind_next;
  logic              out_free;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_sum      <= ZERO_SUM_RST;
      span_sum      <= SPAN_SUM_RST;
      full_scale_pa <= FULL_SCALE_PA_RST;
      offset_pa     <= OFFSET_PA_RST;
      atmos_pa      <= ATMOS_PA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ZERO_SUM:      zero_sum      <= cfg_data;
        REG_SPAN_SUM:      span_sum      <= cfg_data;
        REG_FULL_SCALE_PA: full_scale_pa <= cfg_data;
        REG_OFFSET_PA:     offset_pa     <= cfg_data;
        REG_ATMOS_PA:      atmos_pa      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Burst accumulator
  assign sample_stall = (state != S_IDLE) || acc.full;
  assign take         = sample_valid && !sample_stall;
  assign clear        = (state == S_IDLE) && acc.full;

  tmps_accum #(
    .SAMPLES  (SAMPLES),
    .ADC_BITS (ADC_BITS)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .clear  (clear),
    .sample (sample),
    .status (acc)
  );

  // Serial multiply-divide: (tsum - zero_sum) * full_scale_pa / span_sum
  assign md_req.start = clear;
  assign md_req.a     = (acc.tsum > zero_sum) ? (acc.tsum - zero_sum) : '0;
  assign md_req.b     = full_scale_pa;
  assign md_req.d     = span_sum;

  tmps_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .req      (md_req),
    .done     (md_done),
    .quotient (md_quot)
  );

  // Offset and full-scale clamp
  assign scaled    = below_zero ? '0 : md_quot;
  assign over      = scaled - PROD_W'(offset_pa);
  assign wind_next = (scaled <= PROD_W'(offset_pa)) ? '0 :
                     (over > PROD_W'(full_scale_pa)) ? full_scale_pa : over[DATA_W-1:0];

  assign out_free = !result_valid || !result_stall;

  // Sequence one burst through trim, scale, clamp and load
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (clear)    state <= S_CALC;
        S_CALC:  if (md_done)  state <= S_CLAMP;
        S_CLAMP:               state <= S_LOAD;
        S_LOAD:  if (out_free) state <= S_IDLE;
        default:               state <= S_IDLE;
      endcase
    end
  end

  // Hold the burst's trimmed sum and clamp results
  always_ff @(posedge clk) begin
    if (clear) begin
      tsum       <= acc.tsum;
      below_zero <= acc.tsum <= zero_sum;
    end
    if (state == S_CLAMP) begin
      wind <= wind_next;
    end
  end

  // Output register: load on a free slot, drop after the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_LOAD && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && out_free) begin
      pressure_pa <= (wind > atmos_pa) ? (wind - atmos_pa) : '0;
      trimmed_sum <= tsum;
    end
  end

`ifndef SYNTHESIS
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_CALC)
    else $error("multiply-divide finished outside the calculation phase");

  a_burst_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && acc.full) |=> (state == S_CALC && !acc.full))
    else $error("full burst did not start the scaler");

  a_below_zero_wind: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && below_zero) |-> wind == '0)
    else $error("reading at or below zero level gave nonzero wind");

  a_wind_clamped: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> wind <= full_scale_pa)
    else $error("wind above full scale");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tmps_pkg::*;

  localparam int BURST_LEN = 16;
  localparam int ADC_W = 12;
  localparam int SCALE_LATENCY = 53;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [DATA_W-1:0] pressure;
    logic [DATA_W-1:0] tsum;
  } reading_t;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  logic [SAMPLE_W-1:0] sample;
  logic result_valid;
  logic result_stall;
  logic [DATA_W-1:0] pressure_pa;
  logic [DATA_W-1:0] trimmed_sum;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // Calibration as the block should hold it
  logic [DATA_W-1:0] cal_zero;
  logic [DATA_W-1:0] cal_span;
  logic [DATA_W-1:0] cal_full;
  logic [DATA_W-1:0] cal_offset;
  logic [DATA_W-1:0] cal_atmos;

  // Burst accumulator state
  int burst_count;
  logic [17:0] burst_total;
  logic [ADC_W-1:0] burst_max;
  logic [ADC_W-1:0] burst_min;

  reading_t expected_readings[$];
  reading_t want;
  logic [SAMPLE_W-1:0] burst_buf[BURST_LEN];
  bit gaps_on;
  int stall_left;
  int errors;
  int cycle_count;

  trimmed_mean_pressure_scaler_unit #(
    .SAMPLES(BURST_LEN),
    .ADC_BITS(ADC_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .pressure_pa(pressure_pa),
    .trimmed_sum(trimmed_sum),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Scale a trimmed sum as a 4-20 mA reading, then apply offset and atmosphere
  function automatic logic [DATA_W-1:0] scale_to_pascals(input logic [DATA_W-1:0] tsum);
    logic [63:0] excess;
    logic [63:0] scaled;
    logic [DATA_W-1:0] wind;
    excess = tsum;
    excess = excess - cal_zero;
    if (tsum <= cal_zero) begin
      scaled = 64'd0;
    end else if (cal_span == '0) begin
      scaled = '1;
    end else begin
      scaled = (excess * 64'(cal_full)) / 64'(cal_span);
    end
    if (scaled <= 64'(cal_offset)) begin
      wind = '0;
    end else begin
      scaled = scaled - 64'(cal_offset);
      wind = (scaled > 64'(cal_full)) ? cal_full : scaled[DATA_W-1:0];
    end
    return (wind > cal_atmos) ? DATA_W'(wind - cal_atmos) : '0;
  endfunction

  function automatic void clear_burst();
    burst_count = 0;
    burst_total = '0;
    burst_max = '0;
    burst_min = '1;
  endfunction

  // Fold one accepted sample into the burst; queue a reading on the last one
  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] value);
    logic [17:0] trimmed;
    reading_t r;
    burst_total = burst_total + value;
    if (value > burst_max) burst_max = value;
    if (value < burst_min) burst_min = value;
    burst_count++;
    if (burst_count == BURST_LEN) begin
      trimmed = burst_total - burst_max - burst_min;
      if (trimmed > 18'hFFFF) trimmed = 18'hFFFF;
      r.tsum = trimmed[DATA_W-1:0];
      r.pressure = scale_to_pascals(r.tsum);
      expected_readings.push_back(r);
      clear_burst();
    end
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Send one sample transaction, with an optional idle burst ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    accumulate_sample(value);
    @(negedge clk);
  endtask

  task automatic send_burst();
    for (int i = 0; i < BURST_LEN; i++) send_sample(burst_buf[i]);
  endtask

  // Drop valid and wait until every reading is back and the block is quiet
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SCALE_LATENCY + 8) @(negedge clk);
  endtask

  // Hold one write transaction until the block takes it; valid stays high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ZERO_SUM: cal_zero = value;
      REG_SPAN_SUM: cal_span = value;
      REG_FULL_SCALE_PA: cal_full = value;
      REG_OFFSET_PA: cal_offset = value;
      REG_ATMOS_PA: cal_atmos = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_calibration(input logic [DATA_W-1:0] zero, input logic [DATA_W-1:0] span,
                                   input logic [DATA_W-1:0] full, input logic [DATA_W-1:0] offs,
                                   input logic [DATA_W-1:0] atmos);
    wait_drained();
    write_reg(REG_ATMOS_PA + CFG_IDX_W'($urandom_range(1, 3)), DATA_W'($urandom));
    write_reg(REG_ZERO_SUM, zero);
    write_reg(REG_SPAN_SUM, span);
    write_reg(REG_FULL_SCALE_PA, full);
    write_reg(REG_OFFSET_PA, offs);
    write_reg(REG_ATMOS_PA, atmos);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_calibration();
    logic [DATA_W-1:0] full;
    full = pick_value(1, 65535);
    apply_calibration(pick_value(0, 30000), pick_value(2000, 65535), full,
                      pick_value(0, int'(full) / 4), pick_value(0, int'(full) / 8));
  endtask

  // Random burst content: spread, tight cluster, flat with outliers, or extremes
  task automatic fill_random_burst();
    int center;
    int spread;
    int v;
    int mode;
    mode = $urandom_range(0, 3);
    center = $urandom_range(0, 4095);
    spread = $urandom_range(0, 96);
    for (int i = 0; i < BURST_LEN; i++) begin
      case (mode)
        0: v = $urandom_range(0, 4095);
        1: v = center + $urandom_range(0, 2 * spread) - spread;
        2: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : center;
        default: begin
          case ($urandom_range(0, 2))
            0: v = 0;
            1: v = 4095;
            default: v = $urandom_range(0, 4095);
          endcase
        end
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      burst_buf[i] = SAMPLE_W'(v);
    end
  endtask

  // Default calibration: floor, exact zero level, just above it, full input, trim
  task automatic test_default_calibration();
    for (int i = 0; i < BURST_LEN; i++) burst_buf[i] = '0;
    send_burst();
    burst_buf[0] = '0;
    burst_buf[1] = '1;
    burst_buf[2] = SAMPLE_W'(822);
    for (int i = 3; i < BURST_LEN; i++) burst_buf[i] = SAMPLE_W'(819);
    send_burst();
    burst_buf[2] = SAMPLE_W'(823);
    send_burst();
    for (int i = 0; i < BURST_LEN; i++) burst_buf[i] = '1;
    send_burst();
  endtask

  // Zero span, zero full scale, offset and atmosphere above the wind, extremes
  task automatic test_special_calibrations();
    for (int i = 0; i < BURST_LEN; i++) burst_buf[i] = '1;
    apply_calibration(16'd0, 16'd0, 16'd5000, 16'd100, 16'd50);
    send_burst();
    apply_calibration(16'd0, 16'd100, 16'd0, 16'd0, 16'd0);
    send_burst();
    apply_calibration(16'd0, 16'd1, 16'd65535, 16'd65535, 16'd0);
    send_burst();
    apply_calibration(16'd0, 16'd1000, 16'd65535, 16'd0, 16'd65535);
    send_burst();
    apply_calibration(16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0);
    send_burst();
    apply_calibration(16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0);
    send_burst();
  endtask

  task automatic test_random_bursts();
    for (int phase = 0; phase < 9; phase++) begin
      random_calibration();
      for (int b = 0; b < 8; b++) begin
        fill_random_burst();
        send_burst();
      end
    end
  endtask

  // Back to reset calibration, full rate on both sides
  task automatic test_streaming();
    gaps_on = 1'b0;
    apply_calibration(ZERO_SUM_RST, SPAN_SUM_RST, FULL_SCALE_PA_RST, OFFSET_PA_RST,
                      ATMOS_PA_RST);
    for (int b = 0; b < 8; b++) begin
      fill_random_burst();
      send_burst();
    end
  endtask

  // Receiver stalls in random bursts while idling is on
  initial begin
    result_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each result transaction with the oldest expected reading
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual pressure_pa=%0d trimmed_sum=%0d",
                 $time, pressure_pa, trimmed_sum);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (trimmed_sum !== want.tsum) begin
          $display("%0t: trimmed_sum mismatch: expected %0d, actual %0d",
                   $time, want.tsum, trimmed_sum);
          errors++;
        end
        if (pressure_pa !== want.pressure) begin
          $display("%0t: pressure_pa mismatch: expected %0d, actual %0d",
                   $time, want.pressure, pressure_pa);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ZERO_SUM;
    cfg_data = '0;
    errors = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    cal_zero = ZERO_SUM_RST;
    cal_span = SPAN_SUM_RST;
    cal_full = FULL_SCALE_PA_RST;
    cal_offset = OFFSET_PA_RST;
    cal_atmos = ATMOS_PA_RST;
    clear_burst();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_calibration();
    test_special_calibrations();
    test_random_bursts();
    test_streaming();
    wait_drained();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
